### rtl/tfp_pkg.sv
`default_nettype none

package tfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COORD_W = 14;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned FRAME_CELLS = 7;

  localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'hA8;
  localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'hAA;
  localparam logic [BYTE_W-1:0] PRESS_CODE = 8'h41;

  localparam logic [POS_W-1:0] LAST_POS = 3'd7;

  localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CKERR   = 2'd3;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [KIND_W-1:0]  kind_t;

  function automatic coord_t join_coord(input byte_t hi, input byte_t lo);
    join_coord = {hi, 6'b0} | {6'b0, lo};
  endfunction

endpackage

`default_nettype wire

### rtl/tfp_if.sv
`default_nettype none

interface tfp_in_if import tfp_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfp_out_if import tfp_pkg::*; ();
  logic   valid;
  logic   ready;
  kind_t  event_kind;
  coord_t pos_x;
  coord_t pos_y;
  logic   header_flag;

  modport source (output valid, output event_kind, output pos_x, output pos_y,
                  output header_flag, input ready);
  modport sink   (input valid, input event_kind, input pos_x, input pos_y,
                  input header_flag, output ready);
endinterface

`default_nettype wire

### rtl/touch_frame_parser.sv
// Channel  Dir  Handshake       Payload
// in_ch    in   valid / ready   rx_byte[7:0]
// out_ch   out  valid / ready   event_kind[1:0], pos_x[13:0], pos_y[13:0], header_flag
//
// One byte per cycle unless stalled; a frame result is registered on its eighth byte.
// Bytes shift through a row of seven cells; the cell row also folds the check XOR.
// Synchronous active-high rst clears byte count, kept coordinates, header flag and
// out_ch.valid (not the payload). in_ch.ready drops only while a result waits unread.
`default_nettype none

module touch_frame_parser import tfp_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  tfp_in_if.sink   in_ch,
  tfp_out_if.source out_ch
);

  logic [POS_W-1:0] pos;
  logic             header_seen;
  coord_t           kept_x;
  coord_t           kept_y;

  byte_t byte_link [0:FRAME_CELLS];
  byte_t xor_link  [0:FRAME_CELLS];

  logic   in_fire;
  logic   frame_end;
  logic   is_hdr;
  logic   is_sync;
  logic   ck_ok;
  logic   is_press;
  coord_t new_x;
  coord_t new_y;
  logic   res_valid;
  kind_t  res_kind;
  coord_t res_x;
  coord_t res_y;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign byte_link[0] = in_ch.rx_byte;
  assign xor_link[0]  = '0;

  for (genvar i = 0; i < FRAME_CELLS; i++) begin : g_cell
    tfp_cell u_cell (
      .clk      (clk),
      .shift_en (in_fire),
      .byte_in  (byte_link[i]),
      .xor_in   (xor_link[i]),
      .byte_q   (byte_link[i+1]),
      .xor_out  (xor_link[i+1])
    );
  end

  // Oldest byte sits in the last cell. The two sync bytes cancel in the full
  // XOR, so it equals the XOR of bytes 2 to 6 whenever the frame is a sync frame.
  assign frame_end = (pos == LAST_POS);
  assign is_hdr    = (byte_link[7] == HDR_BYTE);
  assign is_sync   = (byte_link[7] == SYNC_BYTE) && (byte_link[6] == SYNC_BYTE);
  assign ck_ok     = (in_ch.rx_byte == xor_link[FRAME_CELLS]);
  assign is_press  = (byte_link[5] == PRESS_CODE);
  assign new_y     = join_coord(byte_link[4], byte_link[3]);
  assign new_x     = join_coord(byte_link[2], byte_link[1]);

  always_comb begin
    res_valid = frame_end && (is_hdr || is_sync);
    res_kind  = KIND_HEADER;
    res_x     = '0;
    res_y     = '0;
    if (!is_hdr) begin
      if (!ck_ok) begin
        res_kind = KIND_CKERR;
      end else if (is_press) begin
        res_kind = KIND_PRESS;
        res_x    = new_x;
        res_y    = new_y;
      end else begin
        res_kind = KIND_RELEASE;
        res_x    = kept_x;
        res_y    = kept_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      header_seen  <= 1'b0;
      kept_x       <= '0;
      kept_y       <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (in_fire) begin
        pos          <= pos + 3'd1;
        out_ch.valid <= res_valid;
        if (frame_end && is_hdr) begin
          header_seen <= 1'b1;
        end
        if (res_valid && res_kind == KIND_PRESS) begin
          kept_x <= new_x;
          kept_y <= new_y;
        end
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_ch.event_kind  <= res_kind;
      out_ch.pos_x       <= res_x;
      out_ch.pos_y       <= res_y;
      out_ch.header_flag <= header_seen || (frame_end && is_hdr);
    end
  end

`ifndef ASSERT_OFF
  a_no_mid_frame_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && pos != LAST_POS |=> !out_ch.valid)
    else $error("result after a mid-frame byte");

  a_header_sticky: assert property (@(posedge clk) disable iff (rst)
    header_seen |=> header_seen)
    else $error("header flag cleared");

  a_header_flag: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.event_kind == KIND_HEADER |-> out_ch.header_flag)
    else $error("header result without header flag");

  a_zero_pos: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.event_kind == KIND_HEADER || out_ch.event_kind == KIND_CKERR)
    |-> out_ch.pos_x == '0 && out_ch.pos_y == '0)
    else $error("coordinates on header or check error");
`endif

endmodule

`default_nettype wire

### rtl/tfp_cell.sv
`default_nettype none

module tfp_cell import tfp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  shift_en,
  input  wire byte_t byte_in,
  input  wire byte_t xor_in,
  output byte_t      byte_q,
  output byte_t      xor_out
);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_q <= byte_in;
    end
  end

  assign xor_out = xor_in ^ byte_q;

endmodule

`default_nettype wire
